// File: rtl/tcpct_pkg.sv
// ----------------------------------------------------------------------------
// tcpct_pkg
// Shared types and codes for the TCP relay connection table: transaction
// payloads, entry and search token layouts, and cell control.
// ----------------------------------------------------------------------------
package tcpct_pkg;

    // default number of table entries
    localparam int unsigned TABLE_DEPTH_DEF = 16;

    // operation codes
    localparam logic [2:0] FUNC_INSERT     = 3'd0;
    localparam logic [2:0] FUNC_DELETE     = 3'd1;
    localparam logic [2:0] FUNC_RD_STATE   = 3'd2;
    localparam logic [2:0] FUNC_WR_STATE   = 3'd3;
    localparam logic [2:0] FUNC_RD_ADDR    = 3'd4;
    localparam logic [2:0] FUNC_SRV_TO_CLI = 3'd5;
    localparam logic [2:0] FUNC_CLI_TO_SRV = 3'd6;
    localparam logic [2:0] FUNC_UNUSED     = 3'd7;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // input transaction
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] ip_addr;
        logic [15:0] client_port;
        logic [15:0] server_port;
        logic [15:0] conn_state;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ip_addr_out;
        logic [15:0] client_port_out;
        logic [15:0] server_port_out;
        logic [15:0] conn_state_out;
    } out_item_t;

    // one table entry
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [15:0] client_port;
        logic [15:0] server_port;
        logic [15:0] conn_state;
    } entry_t;

    // search token walking the chain, newest cell first
    typedef struct packed {
        logic   active;
        logic   hit;
        entry_t ent;
    } token_t;

    // control broadcast to every cell
    typedef struct packed {
        logic        insert;
        logic        del;
        logic        wr;
        logic        by_server;
        logic [15:0] key;
        logic [15:0] new_state;
    } cell_ctrl_t;

endpackage

// File: rtl/tcpct_cell.sv
// ----------------------------------------------------------------------------
// tcpct_cell
// One table entry plus one stage of the search token path. The token picks up
// the first matching entry it passes; the cell remembers whether it was the
// hit and whether it sits at or behind the hit, for the following update.
// ----------------------------------------------------------------------------
module tcpct_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tcpct_pkg::cell_ctrl_t  ctrl,
    input  tcpct_pkg::entry_t      newer_entry,
    input  tcpct_pkg::entry_t      older_entry,
    input  tcpct_pkg::token_t      tok_in,
    output tcpct_pkg::entry_t      entry,
    output tcpct_pkg::token_t      tok_out
);
    import tcpct_pkg::*;

    entry_t entry_reg, entry_next;
    token_t tok_reg, tok_next;
    logic   hit_here_reg, hit_here_next;
    logic   after_hit_reg, after_hit_next;
    logic   key_match;
    logic   take;

    // key compare and token update
    always_comb begin
        key_match = entry_reg.valid &&
                    ((ctrl.by_server ? entry_reg.server_port : entry_reg.client_port)
                     == ctrl.key);
        take      = tok_in.active && !tok_in.hit && key_match;
        tok_next  = tok_in;
        if (take) begin
            tok_next.hit = 1'b1;
            tok_next.ent = entry_reg;
        end
    end

    // hit marks, refreshed as the token passes
    always_comb begin
        hit_here_next  = hit_here_reg;
        after_hit_next = after_hit_reg;
        if (tok_in.active) begin
            hit_here_next  = take;
            after_hit_next = tok_next.hit;
        end
    end

    // entry update: shift older on insert, close the gap on delete, write state at the hit
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert) begin
            entry_next = newer_entry;
        end else if (ctrl.del && after_hit_reg) begin
            entry_next = older_entry;
        end else if (ctrl.wr && hit_here_reg) begin
            entry_next.conn_state = ctrl.new_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
            tok_reg.active  <= 1'b0;
            hit_here_reg    <= 1'b0;
            after_hit_reg   <= 1'b0;
        end else begin
            entry_reg     <= entry_next;
            tok_reg       <= tok_next;
            hit_here_reg  <= hit_here_next;
            after_hit_reg <= after_hit_next;
        end
    end

    assign entry   = entry_reg;
    assign tok_out = tok_reg;

endmodule

// File: rtl/tcp_connection_table.sv
// ----------------------------------------------------------------------------
// tcp_connection_table
// Bounded connection table for a TCP relay, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// The table holds up to TABLE_DEPTH connections in age order, the newest in
// cell 0. One operation is in flight at a time. Insert and the unused code
// go from acceptance straight to the commit state. The searching operations
// (delete, read/write state, read address, port maps) first send a search
// token into the newest cell; it moves one cell per cycle down the chain,
// taking the first matching entry, and is captured as it leaves the oldest
// cell. At commit the table update (insert, state write or gap close on
// delete) is applied and the result waits in an output register for m_valid
// once that register is free; the next transaction is accepted as soon as
// the previous one has been committed. Every search returns the newest
// matching entry; inserts into a full table are refused with status full.
// ----------------------------------------------------------------------------
module tcp_connection_table #(
    parameter int unsigned TABLE_DEPTH = tcpct_pkg::TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tcpct_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tcpct_pkg::out_item_t m_data
);
    import tcpct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } state_t;

    state_t     state_reg;
    in_item_t   req_reg;
    token_t     res_reg;
    logic       launch_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    entry_t     cell_entry  [TABLE_DEPTH];
    entry_t     cell_newer  [TABLE_DEPTH];
    entry_t     cell_older  [TABLE_DEPTH];
    token_t     cell_tok    [TABLE_DEPTH];
    token_t     cell_tok_in [TABLE_DEPTH];

    cell_ctrl_t ctrl;
    entry_t     new_entry;
    token_t     launch_tok;
    out_item_t  result;
    logic       accept;
    logic       out_free;
    logic       commit_fire;
    logic       table_full;
    logic       req_search;
    logic       in_search;

    // handshake and decode
    assign accept      = s_valid && s_ready;
    assign s_ready     = (state_reg == S_IDLE);
    assign out_free    = !m_valid_reg || m_ready;
    assign commit_fire = (state_reg == S_COMMIT) && out_free;
    assign table_full  = cell_entry[TABLE_DEPTH-1].valid;
    assign req_search  = (req_reg.func != FUNC_INSERT) && (req_reg.func != FUNC_UNUSED);
    assign in_search   = (s_data.func != FUNC_INSERT) && (s_data.func != FUNC_UNUSED);

    // new entry and search token for cell 0
    always_comb begin
        new_entry.valid       = 1'b1;
        new_entry.addr        = req_reg.ip_addr;
        new_entry.client_port = req_reg.client_port;
        new_entry.server_port = req_reg.server_port;
        new_entry.conn_state  = req_reg.conn_state;
        launch_tok            = '0;
        launch_tok.active     = launch_reg;
    end

    // control broadcast to the cells
    always_comb begin
        ctrl.insert    = commit_fire && (req_reg.func == FUNC_INSERT) && !table_full;
        ctrl.del       = commit_fire && (req_reg.func == FUNC_DELETE) && res_reg.hit;
        ctrl.wr        = commit_fire && (req_reg.func == FUNC_WR_STATE) && res_reg.hit;
        ctrl.by_server = (req_reg.func == FUNC_SRV_TO_CLI);
        ctrl.key       = ctrl.by_server ? req_reg.server_port : req_reg.client_port;
        ctrl.new_state = req_reg.conn_state;
    end

    // cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_newer[g]  = new_entry;
            assign cell_tok_in[g] = launch_tok;
        end else begin : g_body
            assign cell_newer[g]  = cell_entry[g-1];
            assign cell_tok_in[g] = cell_tok[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign cell_older[g] = '0;
        end else begin : g_mid
            assign cell_older[g] = cell_entry[g+1];
        end

        tcpct_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .newer_entry (cell_newer[g]),
            .older_entry (cell_older[g]),
            .tok_in      (cell_tok_in[g]),
            .entry       (cell_entry[g]),
            .tok_out     (cell_tok[g])
        );
    end

    // result formatting
    always_comb begin
        result = '0;
        if (req_reg.func == FUNC_INSERT) begin
            result.status = table_full ? STATUS_FULL : STATUS_OK;
        end else if (req_search && res_reg.hit) begin
            result.status          = STATUS_OK;
            result.ip_addr_out     = res_reg.ent.addr;
            result.client_port_out = res_reg.ent.client_port;
            result.server_port_out = res_reg.ent.server_port;
            result.conn_state_out  = (req_reg.func == FUNC_WR_STATE) ?
                                     req_reg.conn_state : res_reg.ent.conn_state;
        end else begin
            result.status = STATUS_MISS;
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            launch_reg <= accept && in_search;
            if (m_valid_reg && m_ready && !commit_fire) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg <= s_data;
                        if (in_search) begin
                            state_reg  <= S_SEARCH;
                        end else begin
                            state_reg  <= S_COMMIT;
                        end
                    end
                end
                S_SEARCH: begin
                    if (cell_tok[TABLE_DEPTH-1].active) begin
                        res_reg   <= cell_tok[TABLE_DEPTH-1];
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= result;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/tcpct_checker.sv
// ----------------------------------------------------------------------------
// tcpct_checker
// Port-level checks for the connection table, bound to the top level.
// ----------------------------------------------------------------------------
module tcpct_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input tcpct_pkg::in_item_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input tcpct_pkg::out_item_t m_data
);
    import tcpct_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // only one transaction in flight
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // no new result appears right after an input is accepted
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !($rose(m_valid)))
        else $error("result appeared in the cycle after acceptance");

    // miss and full results carry zero data
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_MISS || m_data.status == STATUS_FULL)
        |-> m_data.ip_addr_out == '0 && m_data.client_port_out == '0 &&
            m_data.server_port_out == '0 && m_data.conn_state_out == '0)
        else $error("nonzero data on miss or full");

    // status code is always meaningful
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STATUS_OK || m_data.status == STATUS_MISS ||
                     m_data.status == STATUS_FULL))
        else $error("undefined status code");

endmodule

bind tcp_connection_table tcpct_checker u_tcpct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: sim/tb_tcp_connection_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_connection_table
// Self-checking testbench for the TCP relay connection table.
// ----------------------------------------------------------------------------
// A local model of the table (age-ordered entries, newest first) predicts the
// result of every accepted transaction. A checker compares each result, field
// by field, with the oldest prediction. Stimulus is a short directed sequence
// followed by random traffic phases that fill, drain and churn the table,
// with random idle cycles on both channels, a stretch without idling and one
// long output stall that backs the block up onto its input.
// ----------------------------------------------------------------------------
module tb_tcp_connection_table;
    import tcpct_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    // predicted table contents, slot 0 newest
    entry_t    conn_tbl [DEPTH];
    out_item_t pending_results [$];

    int          err_count;
    bit          sender_idle;
    bit          receiver_idle;
    int          hold_off_cycles;
    logic [15:0] client_pool [8];
    logic [15:0] server_pool [8];

    tcp_connection_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock, 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // number of valid entries (they always form a prefix)
    function automatic int live_entries();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (conn_tbl[i].valid) n++;
        end
        return n;
    endfunction

    // apply one operation to the local table and return its result
    function automatic out_item_t lookup_connection(in_item_t it);
        out_item_t   r;
        int          hit;
        logic        by_srv;
        logic [15:0] key;
        r = '0;
        r.status = STATUS_MISS;
        if (it.func == FUNC_INSERT) begin
            if (conn_tbl[DEPTH-1].valid) begin
                r.status = STATUS_FULL;
                return r;
            end
            for (int i = DEPTH - 1; i > 0; i--) conn_tbl[i] = conn_tbl[i-1];
            conn_tbl[0].valid       = 1'b1;
            conn_tbl[0].addr        = it.ip_addr;
            conn_tbl[0].client_port = it.client_port;
            conn_tbl[0].server_port = it.server_port;
            conn_tbl[0].conn_state  = it.conn_state;
            r.status = STATUS_OK;
            return r;
        end
        if (it.func == FUNC_UNUSED) return r;
        by_srv = (it.func == FUNC_SRV_TO_CLI);
        key = by_srv ? it.server_port : it.client_port;
        hit = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (hit < 0 && conn_tbl[i].valid &&
                (by_srv ? conn_tbl[i].server_port : conn_tbl[i].client_port) == key)
                hit = i;
        end
        if (hit < 0) return r;
        if (it.func == FUNC_WR_STATE) conn_tbl[hit].conn_state = it.conn_state;
        r.status          = STATUS_OK;
        r.ip_addr_out     = conn_tbl[hit].addr;
        r.client_port_out = conn_tbl[hit].client_port;
        r.server_port_out = conn_tbl[hit].server_port;
        r.conn_state_out  = conn_tbl[hit].conn_state;
        if (it.func == FUNC_DELETE) begin
            for (int i = hit; i < DEPTH - 1; i++) conn_tbl[i] = conn_tbl[i+1];
            conn_tbl[DEPTH-1].valid = 1'b0;
        end
        return r;
    endfunction

    function automatic in_item_t make_item(logic [2:0] func, logic [31:0] ip,
                                           logic [15:0] cp, logic [15:0] sp,
                                           logic [15:0] st);
        in_item_t it;
        it.func        = func;
        it.ip_addr     = ip;
        it.client_port = cp;
        it.server_port = sp;
        it.conn_state  = st;
        return it;
    endfunction

    // port from a live entry, a small pool, or anywhere in the range
    function automatic logic [15:0] pick_port(bit server);
        int n;
        int j;
        n = live_entries();
        if (n > 0 && $urandom_range(0, 99) < 55) begin
            j = $urandom_range(0, n - 1);
            return server ? conn_tbl[j].server_port : conn_tbl[j].client_port;
        end
        if ($urandom_range(0, 99) < 75)
            return server ? server_pool[$urandom_range(0, 7)] : client_pool[$urandom_range(0, 7)];
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic in_item_t random_item(int insert_pct, int delete_pct);
        in_item_t it;
        int       r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            it.func = FUNC_INSERT;
        else if (r < insert_pct + delete_pct)
            it.func = FUNC_DELETE;
        else if (r < insert_pct + delete_pct + 3)
            it.func = FUNC_UNUSED;
        else
            it.func = 3'($urandom_range(FUNC_RD_STATE, FUNC_CLI_TO_SRV));
        it.ip_addr     = $urandom;
        it.client_port = pick_port(1'b0);
        it.server_port = pick_port(1'b1);
        it.conn_state  = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        err_count++;
    endtask

    // offer one transaction and record its prediction on acceptance
    task automatic send_item(in_item_t it);
        int gap;
        gap = sender_idle ? $urandom_range(0, 16) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(lookup_connection(it));
    endtask

    // misses on an empty table, inserts at the field extremes, duplicates,
    // newest-match, write then read, delete exposing an older copy
    task automatic test_directed();
        send_item(make_item(FUNC_RD_STATE,   32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_DELETE,     32'h0,        16'hffff, 16'hffff, 16'hffff));
        send_item(make_item(FUNC_WR_STATE,   32'h0,        16'h0000, 16'h0000, 16'hffff));
        send_item(make_item(FUNC_RD_ADDR,    32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_SRV_TO_CLI, 32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_CLI_TO_SRV, 32'h0,        16'hffff, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_UNUSED,     32'hffffffff, 16'hffff, 16'hffff, 16'hffff));
        send_item(make_item(FUNC_INSERT,     32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_INSERT,     32'hffffffff, 16'hffff, 16'hffff, 16'hffff));
        send_item(make_item(FUNC_INSERT,     32'h0a000001, 16'h0000, 16'h1234, 16'h0005));
        send_item(make_item(FUNC_RD_STATE,   32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_RD_ADDR,    32'h0,        16'hffff, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_SRV_TO_CLI, 32'h0,        16'h0000, 16'hffff, 16'h0000));
        send_item(make_item(FUNC_SRV_TO_CLI, 32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_CLI_TO_SRV, 32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_WR_STATE,   32'h0,        16'h0000, 16'h0000, 16'habcd));
        send_item(make_item(FUNC_RD_STATE,   32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_DELETE,     32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_RD_STATE,   32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_UNUSED,     32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_DELETE,     32'h0,        16'hffff, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_DELETE,     32'h0,        16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(FUNC_RD_ADDR,    32'h0,        16'h0000, 16'h0000, 16'h0000));
    endtask

    // random traffic with a given mix of inserts and deletes
    task automatic test_random_traffic(int count, int insert_pct, int delete_pct);
        for (int n = 0; n < count; n++) send_item(random_item(insert_pct, delete_pct));
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_stall();
        sender_idle     = 1'b0;
        hold_off_cycles = 300;
        test_random_traffic(60, 40, 20);
        sender_idle     = 1'b1;
    endtask

    // result side: random stalls, plus the requested long hold-off
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = receiver_idle ? $urandom_range(0, 16) : 0;
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                stall           = stall + hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge aclk) begin : result_checker
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("[%0t] result with no transaction pending: %h", $realtime, m_data);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_data.status));
                if (m_data.ip_addr_out !== want.ip_addr_out)
                    report_mismatch("ip_addr_out", want.ip_addr_out, m_data.ip_addr_out);
                if (m_data.client_port_out !== want.client_port_out)
                    report_mismatch("client_port_out", 32'(want.client_port_out),
                                    32'(m_data.client_port_out));
                if (m_data.server_port_out !== want.server_port_out)
                    report_mismatch("server_port_out", 32'(want.server_port_out),
                                    32'(m_data.server_port_out));
                if (m_data.conn_state_out !== want.conn_state_out)
                    report_mismatch("conn_state_out", 32'(want.conn_state_out),
                                    32'(m_data.conn_state_out));
            end
        end
    end

    // main sequence
    initial begin
        int drain;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        err_count       = 0;
        sender_idle     = 1'b1;
        receiver_idle   = 1'b1;
        hold_off_cycles = 0;
        for (int i = 0; i < DEPTH; i++) conn_tbl[i] = '0;
        client_pool[0] = 16'h0000;
        client_pool[1] = 16'hffff;
        server_pool[0] = 16'h0000;
        server_pool[1] = 16'hffff;
        for (int i = 2; i < 8; i++) begin
            client_pool[i] = 16'($urandom_range(0, 65535));
            server_pool[i] = 16'($urandom_range(0, 65535));
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_traffic(400, 30, 25);
        test_random_traffic(300, 65, 10);
        test_random_traffic(300, 10, 50);
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random_traffic(250, 35, 25);
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        test_output_stall();
        test_random_traffic(220, 45, 20);

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain outstanding results, then let the block settle
        drain = 0;
        while (pending_results.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (4 * (DEPTH + 3)) @(posedge aclk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
